// ===== sv/wsfd_pkg.sv =====
// shared types and constants for the websocket frame deframer
// no dependencies; imported by wsfd_parser and websocket_frame_deframer_top
package wsfd_pkg;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_B0      = 5'b00001,
        PH_B1      = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_INCONS  = 2'd2;
    localparam logic [1:0] KIND_CTRLVIO = 2'd3;

    // header length codes and header byte counts
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [3:0] HC_EXT16  = 4'd2;
    localparam logic [3:0] HC_EXT64  = 4'd8;
    localparam logic [3:0] HC_KEY    = 4'd4;

    // reset value of the expected type register (text)
    localparam logic [3:0] EXP_TYPE_RESET = 4'd1;

    // one result item
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] frame_type;
        logic [7:0] out_byte;
        logic       frame_last;
        logic       message_final;
    } result_t;

endpackage

// ===== sv/wsfd_parser.sv =====
// frame parser: header state machine, length and key collection, unmasking
// depends on wsfd_pkg
module wsfd_parser
    import wsfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic [3:0] expected_type,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  hc_reg, hc_next;
    logic [63:0] rem_reg, rem_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  idx_reg, idx_next;
    logic        masked_reg, masked_next;
    logic        fin_reg, fin_next;
    logic [3:0]  type_reg, type_next;
    logic        frag_reg, frag_next;
    logic        drop_reg, drop_next;

    logic        do_finish;
    logic [63:0] rem_fin;
    logic [3:0]  hc_dec;
    logic [3:0]  t;
    logic [1:0]  err;
    logic [7:0]  key_byte;
    logic        last;
    logic        empty;

    // next state and result for one byte
    always_comb begin
        phase_next  = phase_reg;
        hc_next     = hc_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        masked_next = masked_reg;
        fin_next    = fin_reg;
        type_next   = type_reg;
        frag_next   = frag_reg;
        drop_next   = drop_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.message_final = fin_reg;
        do_finish   = 1'b0;
        rem_fin     = rem_reg;
        hc_dec      = hc_reg - 4'd1;
        t           = type_reg;
        err         = KIND_HEADER;
        key_byte    = key_reg[{~idx_reg, 3'b000} +: 8];
        last        = (rem_reg[63:1] == 63'd0);
        empty       = 1'b0;

        case (phase_reg)
            PH_B0: begin
                fin_next   = in_byte[7];
                type_next  = in_byte[3:0];
                phase_next = PH_B1;
            end
            PH_B1: begin
                masked_next = in_byte[7];
                if (in_byte[6:0] == LEN_EXT16 || in_byte[6:0] == LEN_EXT64) begin
                    hc_next    = (in_byte[6:0] == LEN_EXT16) ? HC_EXT16 : HC_EXT64;
                    rem_next   = '0;
                    phase_next = PH_EXTLEN;
                end else begin
                    rem_fin  = {57'd0, in_byte[6:0]};
                    rem_next = rem_fin;
                    if (in_byte[7]) begin
                        phase_next = PH_MASK;
                        hc_next    = HC_KEY;
                        key_next   = '0;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
            PH_EXTLEN: begin
                rem_fin  = {rem_reg[55:0], in_byte};
                rem_next = rem_fin;
                hc_next  = hc_dec;
                if (hc_dec == 4'd0) begin
                    if (masked_reg) begin
                        phase_next = PH_MASK;
                        hc_next    = HC_KEY;
                        key_next   = '0;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
            PH_MASK: begin
                key_next = {key_reg[23:0], in_byte};
                hc_next  = hc_dec;
                if (hc_dec == 4'd0) begin
                    do_finish = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                idx_next = idx_reg + 2'd1;
                if (rem_reg != 64'd0) begin
                    rem_next = rem_reg - 64'd1;
                end
                if (last) begin
                    phase_next = PH_B0;
                end
                if (drop_reg) begin
                    if (last) begin
                        drop_next = 1'b0;
                    end
                end else begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_PAYLOAD;
                    res.frame_type = type_reg;
                    res.out_byte   = masked_reg ? (in_byte ^ key_byte) : in_byte;
                    res.frame_last = last;
                end
            end
            default: begin
                phase_next = PH_B0;
            end
        endcase

        // end of header: resolve continuation and check the type
        if (do_finish) begin
            if (frag_reg) begin
                if (type_reg == 4'd0) begin
                    t = expected_type;
                    if (fin_reg) begin
                        frag_next = 1'b0;
                    end
                end
            end else if (!fin_reg) begin
                frag_next = 1'b1;
            end
            if (!fin_reg) begin
                if (t != expected_type) begin
                    err = t[3] ? KIND_CTRLVIO : KIND_INCONS;
                end
            end else if (!t[3] && t != expected_type) begin
                err = KIND_INCONS;
            end
            empty          = (rem_fin == 64'd0);
            type_next      = t;
            idx_next       = 2'd0;
            drop_next      = (err != KIND_HEADER);
            phase_next     = empty ? PH_B0 : PH_PAYLOAD;
            res_valid      = 1'b1;
            res.kind       = err;
            res.frame_type = t;
            res.frame_last = (err == KIND_HEADER) && empty;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_B0;
            hc_reg     <= '0;
            rem_reg    <= '0;
            key_reg    <= '0;
            idx_reg    <= '0;
            masked_reg <= 1'b0;
            fin_reg    <= 1'b0;
            type_reg   <= '0;
            frag_reg   <= 1'b0;
            drop_reg   <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            rem_reg    <= rem_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
            masked_reg <= masked_next;
            fin_reg    <= fin_next;
            type_reg   <= type_next;
            frag_reg   <= frag_next;
            drop_reg   <= drop_next;
        end
    end

    // header byte counter never sits at zero while collecting
    a_hc_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_EXTLEN || phase_reg == PH_MASK) |-> hc_reg != 4'd0)
        else $error("header count zero while collecting header bytes");

endmodule

// ===== sv/websocket_frame_deframer_top.sv =====
// Path: an accepted byte is loaded into the input register; when it advances, the parser
// logic feeds its result, if it yields one, into the result register.
// Throughput: one byte per cycle sustained; ready drops only under result backpressure.
// Reset: synchronous active-low aresetn clears the parser to wait for a first
// header byte, empties both registers, and sets expected_type to 1 (text).
// top level; depends on wsfd_pkg and wsfd_parser
module websocket_frame_deframer_top
    import wsfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_expected_type,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [3:0] m_frame_type,
    output logic [7:0] m_out_byte,
    output logic       m_frame_last,
    output logic       m_message_final
);

    logic [3:0] exp_type_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       advance;
    logic       res_valid;
    result_t    res;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_type_reg <= EXP_TYPE_RESET;
        end else if (cfg_valid) begin
            exp_type_reg <= cfg_expected_type;
        end
    end

    // the held byte moves on when the result slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    wsfd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .in_byte       (in_byte_reg),
        .expected_type (exp_type_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_frame_type    = out_reg.frame_type;
    assign m_out_byte      = out_reg.out_byte;
    assign m_frame_last    = out_reg.frame_last;
    assign m_message_final = out_reg.message_final;

    // error requests carry no byte and no last marker
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_INCONS || m_kind == KIND_CTRLVIO)
            |-> m_out_byte == 8'd0 && !m_frame_last)
        else $error("error request with byte or last marker");

    // header-done requests carry no byte
    a_hdr_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_HEADER |-> m_out_byte == 8'd0)
        else $error("header request with nonzero byte");

    // input stalls only while a byte is held behind a full result register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without result backpressure");

    // a byte held behind a stalled result is not lost
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input byte changed while stalled");

endmodule
